### hdl/pstbl_pkg.sv
// ----------------------------------------------------------------------------
// pstbl_pkg
// Shared constants for the per-source token bucket limiter.
// ----------------------------------------------------------------------------
`default_nettype none
package pstbl_pkg;
   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_BURST    = 2'd1;
   localparam logic [1:0] CSR_RATE     = 2'd2;
endpackage
`default_nettype wire

### hdl/pstbl_fifo.sv
// ----------------------------------------------------------------------------
// pstbl_fifo
// Two-entry item queue between the lookup front and the bucket back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pstbl_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule
`default_nettype wire

### hdl/pstbl_front.sv
// ----------------------------------------------------------------------------
// pstbl_front
// Accepts items, matches the key against all entries, updates the valid bits,
// recency ranks and tracked count, and passes slot and flags to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pstbl_front #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 64,
   localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [4:0]    capacity,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [63:0]   req_source_key,
   input  wire logic [31:0]   req_timestamp,
   output logic               q_valid,
   input  wire logic          q_ready,
   output logic [SW-1:0]      q_slot,
   output logic               q_new,
   output logic               q_evict,
   output logic [CW-1:0]      q_tracked,
   output logic [31:0]        q_time
);
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_OUT  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_BITS-1:0]  key_ff [MAX_ENTRIES];
   logic [SW-1:0]        rank_ff [MAX_ENTRIES];
   logic [CW-1:0]        tracked_ff, tracked_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic                 new_ff, new_in, ev_ff, ev_in;
   logic [31:0]          time_ff;
   logic [MAX_ENTRIES-1:0] hit;
   logic                 found;
   logic [SW-1:0]        hslot, fslot, vslot, lim_rank;
   logic [CW-1:0]        limit;
   logic [SW:0]          rank_lim;
   logic                 accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign q_valid   = (state_ff == ST_OUT);
   assign q_slot = slot_ff; assign q_new = new_ff; assign q_evict = ev_ff;
   assign q_tracked = tracked_ff; assign q_time = time_ff;

   always_comb begin
      if (capacity == 5'd0) limit = CW'(1);
      else if (32'(capacity) > MAX_ENTRIES) limit = CW'(MAX_ENTRIES);
      else limit = CW'(capacity);
      found = 1'b0; hslot = '0; fslot = '0; vslot = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         hit[i] = valid_ff[i] && (key_ff[i] == req_source_key[KEY_BITS-1:0]);
         if (hit[i]) begin found = 1'b1; hslot = SW'(i); end
      end
      lim_rank = SW'(tracked_ff - CW'(1));
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && rank_ff[i] == lim_rank) vslot = SW'(i);
      end
      valid_in = valid_ff; tracked_in = tracked_ff; ev_in = 1'b0;
      if (!found && tracked_ff >= limit && tracked_ff != '0) begin
         valid_in[vslot] = 1'b0; tracked_in = tracked_ff - CW'(1); ev_in = 1'b1;
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_in[i]) fslot = SW'(i);
      end
      new_in = !found;
      slot_in = found ? hslot : fslot;
      rank_lim = found ? {1'b0, rank_ff[hslot]} : {1'b1, {SW{1'b0}}};
      if (!found) begin
         valid_in[fslot] = 1'b1; tracked_in = tracked_in + CW'(1);
      end
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_OUT;
         ST_OUT:  if (q_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (SW'(i) != slot_in && valid_in[i] && {1'b0, rank_ff[i]} < rank_lim)
               rank_ff[i] <= rank_ff[i] + SW'(1);
         end
         rank_ff[slot_in] <= '0;
         key_ff[slot_in]  <= req_source_key[KEY_BITS-1:0];
         slot_ff <= slot_in; new_ff <= new_in; ev_ff <= ev_in;
         time_ff <= req_timestamp;
      end
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; tracked_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin valid_ff <= valid_in; tracked_ff <= tracked_in; end
      end
   end
endmodule
`default_nettype wire

### hdl/pstbl_back.sv
// ----------------------------------------------------------------------------
// pstbl_back
// Refills the bucket of the chosen slot, takes a token if one is there and keeps the totals.
// ----------------------------------------------------------------------------
`default_nettype none
module pstbl_back #(
   parameter int MAX_ENTRIES   = 16,
   parameter int FRACTION_BITS = 16,
   localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [15:0]   burst,
   input  wire logic [31:0]   rate,
   input  wire logic          q_valid,
   output logic               q_ready,
   input  wire logic [SW-1:0] q_slot,
   input  wire logic          q_new,
   input  wire logic          q_evict,
   input  wire logic [CW-1:0] q_tracked,
   input  wire logic [31:0]   q_time,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_allowed,
   output logic               rsp_was_new,
   output logic               rsp_evicted_one,
   output logic [4:0]         rsp_sources_tracked,
   output logic [31:0]        rsp_admit_total,
   output logic [31:0]        rsp_drop_total,
   output logic [31:0]        rsp_eviction_total
);
   localparam int TW = 16 + FRACTION_BITS;
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_MUL = 4'b0010, ST_UPD = 4'b0100, ST_OUT = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [TW-1:0]  tok_ff [MAX_ENTRIES];
   logic [31:0]    last_ff [MAX_ENTRIES];
   logic [SW-1:0]  slot_ff;
   logic           new_ff, ev_ff;
   logic [CW-1:0]  trk_ff;
   logic [31:0]    now_ff, el_ff;
   logic [63:0]    add_ff;
   logic [TW-1:0]  cur, tok;
   logic [TW-1:0]  cap, one;
   logic           allow;
   logic [31:0]    adm_ff, drp_ff, evc_ff;

   assign cap = {burst, {FRACTION_BITS{1'b0}}};
   assign one = TW'(1) << FRACTION_BITS;
   assign q_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_was_new = new_ff; assign rsp_evicted_one = ev_ff;
   assign rsp_sources_tracked = 5'(trk_ff);
   assign rsp_admit_total = adm_ff; assign rsp_drop_total = drp_ff;
   assign rsp_eviction_total = evc_ff;

   always_comb begin
      cur = new_ff ? cap : tok_ff[slot_ff];
      if (cur >= cap || add_ff >= 64'(cap - cur)) tok = cap;
      else tok = cur + TW'(add_ff);
      allow = (tok >= one);
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_UPD;
         ST_UPD:  state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid) begin
         slot_ff <= q_slot; new_ff <= q_new; ev_ff <= q_evict;
         trk_ff <= q_tracked; now_ff <= q_time;
         el_ff <= q_new ? 32'd0 : q_time - last_ff[q_slot];
      end
      if (state_ff == ST_MUL) add_ff <= 64'(el_ff) * 64'(rate);
      if (state_ff == ST_UPD) begin
         tok_ff[slot_ff]  <= allow ? tok - one : tok;
         last_ff[slot_ff] <= now_ff;
         rsp_allowed <= allow;
      end
      if (reset) begin
         state_ff <= ST_IDLE; adm_ff <= '0; drp_ff <= '0; evc_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPD) begin
            if (allow) adm_ff <= adm_ff + 32'd1;
            else drp_ff <= drp_ff + 32'd1;
            if (ev_ff) evc_ff <= evc_ff + 32'd1;
         end
      end
   end
endmodule
`default_nettype wire

### hdl/per_source_token_bucket_limiter_core.sv
// ----------------------------------------------------------------------------
// per_source_token_bucket_limiter_core
// Per-source token bucket limiter with a least recently used source table.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/ready     source_key, timestamp
//   rsp      out  rsp_valid/ready     allowed .. eviction_total
//   csr      in   csr_write_enable    csr_index, csr_write_data
//
// Front: key match over all entries, rank update, then hands the item to the queue.
// Back: load, 32x32 refill multiply, update, output.
// Neither end takes a new item until it has passed on the last one.
// Synchronous reset clears valid bits, count and totals; no clearing pass.
// A stalled rsp holds the back end; the queue lets the front run on until it is full.
// ----------------------------------------------------------------------------
`default_nettype none
module per_source_token_bucket_limiter_core #(
   parameter int MAX_ENTRIES   = 16,
   parameter int KEY_BITS      = 64,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_source_key,
   input  wire logic [31:0] req_timestamp,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_allowed,
   output logic             rsp_was_new,
   output logic             rsp_evicted_one,
   output logic [4:0]       rsp_sources_tracked,
   output logic [31:0]      rsp_admit_total,
   output logic [31:0]      rsp_drop_total,
   output logic [31:0]      rsp_eviction_total
);
   localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int QW = SW + 2 + CW + 32;

   logic [4:0]  cap_ff;
   logic [15:0] burst_ff;
   logic [31:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 5'd16; burst_ff <= 16'd10; rate_ff <= 32'd65;
      end else if (csr_write_enable) begin
         case (csr_index)
            pstbl_pkg::CSR_CAPACITY: cap_ff   <= csr_write_data[4:0];
            pstbl_pkg::CSR_BURST:    burst_ff <= csr_write_data[15:0];
            pstbl_pkg::CSR_RATE:     rate_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic          fv, fr, bv, br;
   logic [SW-1:0] fslot, bslot;
   logic          fnew, fev, bnew, bev;
   logic [CW-1:0] ftrk, btrk;
   logic [31:0]   ftime, btime;

   pstbl_front #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_front (
      .clock, .reset, .capacity(cap_ff),
      .req_valid, .req_ready, .req_source_key, .req_timestamp,
      .q_valid(fv), .q_ready(fr), .q_slot(fslot), .q_new(fnew), .q_evict(fev),
      .q_tracked(ftrk), .q_time(ftime));

   pstbl_fifo #(.WIDTH(QW)) u_fifo (
      .clock, .reset,
      .wr_valid(fv), .wr_ready(fr), .wr_data({fslot, fnew, fev, ftrk, ftime}),
      .rd_valid(bv), .rd_ready(br), .rd_data({bslot, bnew, bev, btrk, btime}));

   pstbl_back #(.MAX_ENTRIES(MAX_ENTRIES), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock, .reset, .burst(burst_ff), .rate(rate_ff),
      .q_valid(bv), .q_ready(br), .q_slot(bslot), .q_new(bnew), .q_evict(bev),
      .q_tracked(btrk), .q_time(btime),
      .rsp_valid, .rsp_ready, .rsp_allowed, .rsp_was_new, .rsp_evicted_one,
      .rsp_sources_tracked, .rsp_admit_total, .rsp_drop_total,
      .rsp_eviction_total);

   a_evict_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_one |-> rsp_was_new)
      else $error("eviction without new source");
   a_tracked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_sources_tracked) <= MAX_ENTRIES))
      else $error("tracked count above table size");
   a_new_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_new |-> rsp_sources_tracked != 5'd0)
      else $error("new source with empty table");
endmodule
`default_nettype wire

### sim/per_source_token_bucket_limiter_core_tb.sv
// ----------------------------------------------------------------------------
// per_source_token_bucket_limiter_core_tb
// Drives message items through the limiter, mostly with random idling on both sides,
// predicts each result from its own model of the source table and buckets,
// and compares every returned item field by field, across several register
// settings including capacity, burst and rate extremes.
// ----------------------------------------------------------------------------
module per_source_token_bucket_limiter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS   = 16;
   localparam int FRAC     = 16;
   localparam int WDOG_MAX = 20000;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] stamp;
   } msg_t;

   typedef struct packed {
      logic        allowed;
      logic        was_new;
      logic        evicted_one;
      logic [4:0]  tracked;
      logic [31:0] admits;
      logic [31:0] drops;
      logic [31:0] evictions;
   } verdict_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = pstbl_pkg::CSR_CAPACITY;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_source_key = '0;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_allowed, rsp_was_new, rsp_evicted_one;
   logic [4:0]  rsp_sources_tracked;
   logic [31:0] rsp_admit_total, rsp_drop_total, rsp_eviction_total;

   per_source_token_bucket_limiter_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic        slot_valid [NSLOTS];
   logic [63:0] slot_key   [NSLOTS];
   logic [63:0] slot_tokens[NSLOTS];
   logic [31:0] slot_time  [NSLOTS];
   int unsigned slot_rank  [NSLOTS];
   int unsigned n_tracked;
   logic [31:0] n_admit, n_drop, n_evict;
   logic [4:0]  cfg_capacity;
   logic [15:0] cfg_burst;
   logic [31:0] cfg_rate;

   msg_t        pending_msgs[$];
   verdict_t    expected_verdicts[$];
   int          mismatches = 0;
   int          n_checked = 0;
   int          n_sent = 0;
   int          n_allowed_seen = 0;
   int          n_evict_seen = 0;
   bit          idling_on = 1'b1;
   bit          req_taken = 1'b0;
   int          rsp_hold = 0;
   int          stall_left = 0;
   int          gap_left = 0;
   int          wdog = 0;
   logic [63:0] key_pool[24];
   logic [31:0] clock_ticks = 0;

   function automatic verdict_t limit_message(msg_t m);
      verdict_t    v;
      int          hit, i;
      int unsigned lim, r;
      logic [63:0] cap, add, tok;
      cap = {32'd0, cfg_burst, 16'd0};
      lim = cfg_capacity;
      if (lim < 1) lim = 1;
      if (lim > NSLOTS) lim = NSLOTS;
      v = '0;
      hit = -1;
      for (i = 0; i < NSLOTS; i++)
         if (hit < 0 && slot_valid[i] && slot_key[i] == m.key) hit = i;
      if (hit < 0) begin
         v.was_new = 1'b1;
         if (n_tracked >= lim && n_tracked > 0) begin
            for (i = 0; i < NSLOTS; i++)
               if (!v.evicted_one && slot_valid[i] && slot_rank[i] == n_tracked - 1) begin
                  slot_valid[i] = 1'b0;
                  n_tracked--;
                  n_evict++;
                  v.evicted_one = 1'b1;
               end
         end
         for (i = 0; i < NSLOTS; i++)
            if (hit < 0 && !slot_valid[i]) hit = i;
         for (i = 0; i < NSLOTS; i++)
            if (i != hit && slot_valid[i]) slot_rank[i]++;
         slot_valid[hit]  = 1'b1;
         slot_key[hit]    = m.key;
         slot_tokens[hit] = cap;
         slot_time[hit]   = m.stamp;
         n_tracked++;
      end else begin
         r = slot_rank[hit];
         for (i = 0; i < NSLOTS; i++)
            if (i != hit && slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[hit] = 0;
      add = 64'(32'(m.stamp - slot_time[hit])) * 64'(cfg_rate);
      tok = slot_tokens[hit];
      if (tok >= cap || add >= cap - tok) tok = cap;
      else tok = tok + add;
      slot_time[hit] = m.stamp;
      if (tok >= (64'd1 << FRAC)) begin
         tok = tok - (64'd1 << FRAC);
         v.allowed = 1'b1;
         n_admit++;
      end else begin
         n_drop++;
      end
      slot_tokens[hit] = tok;
      v.tracked   = 5'(n_tracked);
      v.admits    = n_admit;
      v.drops     = n_drop;
      v.evictions = n_evict;
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got %0h expected %0h", n_checked, what, got, want);
      mismatches++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         pstbl_pkg::CSR_CAPACITY: cfg_capacity = val[4:0];
         pstbl_pkg::CSR_BURST:    cfg_burst    = val[15:0];
         default:                 cfg_rate     = val;
      endcase
   endtask

   task automatic drain();
      while (pending_msgs.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic queue_msg(logic [63:0] k, logic [31:0] s);
      msg_t m;
      m.key   = k;
      m.stamp = s;
      pending_msgs.push_back(m);
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_phase(int count, int pool_n, int max_dt);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) queue_msg(rand_key(), $urandom());
         else begin
            clock_ticks = clock_ticks + $urandom_range(0, max_dt);
            queue_msg(key_pool[$urandom_range(0, pool_n - 1)], clock_ticks);
         end
      end
   endtask

   // input acceptance, seen at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_verdicts.push_back(limit_message({req_source_key, req_timestamp}));
         n_sent++;
         req_taken = 1'b1;
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 10);
               req_valid <= 1'b0;
            end else if (pending_msgs.size() != 0) begin
               msg_t m;
               m = pending_msgs.pop_front();
               req_valid      <= 1'b1;
               req_source_key <= m.key;
               req_timestamp  <= m.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         verdict_t w;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected item", 64'd1, 64'd0);
         end else begin
            w = expected_verdicts.pop_front();
            if (rsp_allowed !== w.allowed) report_mismatch("allowed", rsp_allowed, w.allowed);
            if (rsp_was_new !== w.was_new) report_mismatch("was_new", rsp_was_new, w.was_new);
            if (rsp_evicted_one !== w.evicted_one)
               report_mismatch("evicted_one", rsp_evicted_one, w.evicted_one);
            if (rsp_sources_tracked !== w.tracked)
               report_mismatch("sources_tracked", rsp_sources_tracked, w.tracked);
            if (rsp_admit_total !== w.admits)
               report_mismatch("admit_total", rsp_admit_total, w.admits);
            if (rsp_drop_total !== w.drops)
               report_mismatch("drop_total", rsp_drop_total, w.drops);
            if (rsp_eviction_total !== w.evictions)
               report_mismatch("eviction_total", rsp_eviction_total, w.evictions);
            if (w.allowed) n_allowed_seen++;
            if (w.evicted_one) n_evict_seen++;
         end
         n_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || rsp_hold > 0)
         wdog <= 0;
      else
         wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("watchdog: no progress");
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_tokens[i] = '0;
         slot_time[i] = '0;
         slot_rank[i] = 0;
      end
      n_tracked = 0;
      n_admit = '0;
      n_drop = '0;
      n_evict = '0;
      cfg_capacity = 5'd16;
      cfg_burst = 16'd10;
      cfg_rate = 32'd65;
      for (int i = 0; i < 24; i++) key_pool[i] = rand_key();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: extremes of key and time, repeats that run a bucket dry
      queue_msg(64'd0, 32'd0);
      queue_msg(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      queue_msg(64'd0, 32'hFFFF_FFFF);
      queue_msg(64'hFFFF_FFFF_FFFF_FFFF, 32'd5);
      for (int i = 0; i < 12; i++) queue_msg(64'h5555_AAAA_5555_AAAA, 32'd100);
      queue_msg(64'h5555_AAAA_5555_AAAA, 32'd2100);
      drain();

      // capacity zero acts as one, burst zero drops everything
      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd0);
      write_reg(pstbl_pkg::CSR_BURST, 32'd0);
      write_reg(pstbl_pkg::CSR_RATE, 32'hFFFF_FFFF);
      queue_msg(64'h1, 32'd0);
      queue_msg(64'h2, 32'd1);
      queue_msg(64'h2, 32'hFFFF_FFFF);
      drain();

      // capacity lowered below tracked count, tokens above a lowered burst
      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd16);
      write_reg(pstbl_pkg::CSR_BURST, 32'd65535);
      write_reg(pstbl_pkg::CSR_RATE, 32'd0);
      for (int i = 0; i < 6; i++) queue_msg(key_pool[i], 32'd7);
      drain();
      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd2);
      write_reg(pstbl_pkg::CSR_BURST, 32'd3);
      write_reg(pstbl_pkg::CSR_RATE, 32'd1);
      queue_msg(key_pool[7], 32'd8);
      queue_msg(key_pool[3], 32'd9);
      queue_msg(key_pool[8], 32'd9);
      drain();

      // random: tight table with slow refill
      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd4);
      write_reg(pstbl_pkg::CSR_BURST, 32'd2);
      write_reg(pstbl_pkg::CSR_RATE, 32'h0000_4000);
      random_phase(250, 8, 6);
      drain();

      // receiver holds off while the sender keeps offering
      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd31);
      write_reg(pstbl_pkg::CSR_BURST, 32'd1);
      write_reg(pstbl_pkg::CSR_RATE, 32'd300);
      rsp_hold = 300;
      random_phase(250, 24, 400);
      drain();

      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd16);
      write_reg(pstbl_pkg::CSR_BURST, 32'd10);
      write_reg(pstbl_pkg::CSR_RATE, 32'd65);
      random_phase(250, 20, 3000);
      drain();

      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd1);
      write_reg(pstbl_pkg::CSR_BURST, 32'd65535);
      write_reg(pstbl_pkg::CSR_RATE, 32'h0001_0000);
      random_phase(150, 3, 4);
      drain();

      // last part without idling
      idling_on = 1'b0;
      write_reg(pstbl_pkg::CSR_CAPACITY, 32'd10);
      write_reg(pstbl_pkg::CSR_BURST, 32'd3);
      write_reg(pstbl_pkg::CSR_RATE, 32'h0000_8000);
      random_phase(220, 14, 3);
      drain();

      $display("covered %0d items, %0d admitted, %0d with eviction, 9 register settings",
               n_sent, n_allowed_seen, n_evict_seen);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

### files.f
hdl/pstbl_pkg.sv
hdl/pstbl_fifo.sv
hdl/pstbl_front.sv
hdl/pstbl_back.sv
hdl/per_source_token_bucket_limiter_core.sv
sim/per_source_token_bucket_limiter_core_tb.sv
